>>> rtl/osfc_pkg.sv
package osfc_pkg;

  // Problem size and number format (signed, four integer bits)
  localparam int STATE_DIM    = 4;
  localparam int MEAS_DIM     = 2;
  localparam int SAMPLE_WIDTH = 24;
  localparam int FRAC_BITS    = SAMPLE_WIDTH - 4;

  // Coefficient store layout: F row-major, then G row-major, then H
  localparam int G_BASE      = STATE_DIM * STATE_DIM;
  localparam int H_BASE      = G_BASE + STATE_DIM * MEAS_DIM;
  localparam int COEFF_COUNT = H_BASE + STATE_DIM;
  localparam int ROW_LEN     = STATE_DIM + MEAS_DIM;

  // Stream packing
  localparam int IDX_W       = 5;
  localparam int IN_TDATA_W  = ((IDX_W + 3 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int VALUE_LSB   = IDX_W;
  localparam int MEAS0_LSB   = IDX_W + SAMPLE_WIDTH;
  localparam int MEAS1_LSB   = IDX_W + 2 * SAMPLE_WIDTH;

  // Memory address and counter widths
  localparam int CADDR_W = $clog2(COEFF_COUNT);
  localparam int SADDR_W = $clog2(2 * STATE_DIM);
  localparam int ROW_W   = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
  localparam int COL_W   = $clog2(ROW_LEN);
  localparam int MSEL_W  = (MEAS_DIM > 1) ? $clog2(MEAS_DIM) : 1;

  // Datapath widths
  localparam int PROD_W = 2 * SAMPLE_WIDTH;
  localparam int RND_W  = PROD_W - FRAC_BITS;
  localparam int ACC_W  = RND_W + $clog2(ROW_LEN) + 1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // Control that travels alongside one multiply-accumulate through the pipeline
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic              hphase;
    logic              use_meas;
    logic [MSEL_W-1:0] msel;
    logic [ROW_W-1:0]  row;
  } tag_t;

  // Finished dot product, already saturated
  typedef struct packed {
    logic             done;
    logic             hphase;
    logic [ROW_W-1:0] row;
    sample_t          value;
    logic             clipped;
  } row_res_t;

  // The state memory holds two banks of STATE_DIM entries
  function automatic logic [SADDR_W-1:0] st_addr(input logic bank, input int idx);
    int a;
    a = (bank ? STATE_DIM : 0) + idx;
    return SADDR_W'(a);
  endfunction

endpackage

>>> rtl/osfc_ram.sv
module osfc_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;

  // Entry valid bits: an entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Storage with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/osfc_mac.sv
module osfc_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  osfc_pkg::sample_t  coeff_q,
  input  osfc_pkg::sample_t  state_q,
  input  osfc_pkg::sample_t  meas_first,
  input  osfc_pkg::sample_t  meas_second,
  input  osfc_pkg::tag_t     tag_in,
  output osfc_pkg::row_res_t res
);

  import osfc_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF =
    {{(PROD_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_MAX =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  sample_t                   operand;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  biased;
  logic signed [RND_W-1:0]   rnd_nxt;
  logic signed [RND_W-1:0]   rnd_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [ACC_W-1:0]   acc_r;
  tag_t                      tag1_r;
  tag_t                      tag2_r;
  tag_t                      tag3_r;
  logic                      over;
  logic                      under;

  // Second operand: a stored state value or one of the sample's measurements.
  always_comb begin
    if (!tag_in.use_meas) begin
      operand = state_q;
    end else begin
      case (tag_in.msel)
        MSEL_W'(0): operand = meas_first;
        MSEL_W'(1): operand = meas_second;
        default:    operand = '0;
      endcase
    end
  end

  // Stage one: full-precision signed product.
  assign prod_nxt = PROD_W'(coeff_q) * PROD_W'(operand);

  // Stage two: round half up to the fraction width (floor after adding half).
  assign biased  = prod_r + HALF;
  assign rnd_nxt = $signed(biased[PROD_W-1:FRAC_BITS]);

  // Stage three: exact accumulation over one row.
  assign acc_nxt = (tag2_r.first ? ACC_W'(0) : acc_r) + ACC_W'(rnd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    rnd_r  <= rnd_nxt;
    if (tag2_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  // Saturate the finished row to the sample width.
  assign over  = (acc_r > ACC_MAX);
  assign under = (acc_r < ACC_MIN);

  always_comb begin
    res.done    = tag3_r.valid && tag3_r.last;
    res.hphase  = tag3_r.hphase;
    res.row     = tag3_r.row;
    res.clipped = over || under;
    if (over) begin
      res.value = ACC_MAX[SAMPLE_WIDTH-1:0];
    end else if (under) begin
      res.value = ACC_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      res.value = acc_r[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

>>> rtl/observer_state_feedback_controller.sv
// Observer-based state-feedback controller, four states and two measurements.
// Input channel (in_*): in_tuser selects the action. A coefficient load
// (in_tuser = 1) writes one signed Q4.20 coefficient of F, G or H into the
// coefficient memory in the cycle of its transfer; indexes past the store are
// dropped. A sample (in_tuser = 0) computes new_state = F*state + G*y and
// drive = H*new_state through one shared multiply-accumulate pipeline.
// Output channel (out_*): one transfer per sample carries the drive in
// out_tdata and the clip flag in out_tuser.
// A sample runs from its transfer to out_tvalid through these steps: the F and
// G row products, a wait until the last new state is written back to the state
// memory, the H drive products, the pipeline drain and the load of the output
// register. The shared multiplier and the read-after-write wait on the state
// memory set the length of this sequence; the next item is taken in the cycle
// the result appears, and a new sample is not taken before the last one has
// reached the output register.
// Reset clears state and coefficients (both read as zero until written) and
// empties the output register. While the receiver stalls the result stays in
// the output register; further loads and one further sample are still taken,
// and that sample waits for the output register before finishing.
module observer_state_feedback_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // coeff_index, coeff_value, measured_first, measured_second, zero padding
  input  logic [osfc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic [0:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // drive_value
  output logic [osfc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // saturated
  output logic [0:0]                       out_tuser
);

  import osfc_pkg::*;

  localparam int GAP_LEN = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROWS,
    ST_GAP,
    ST_HROW,
    ST_DRAIN,
    ST_PUSH
  } state_t;

  state_t                   state_r;
  logic [ROW_W-1:0]         row_r;
  logic [COL_W-1:0]         col_r;
  logic [1:0]               gap_r;
  logic                     bank_r;
  logic                     sat_r;
  logic                     pend_sat_r;
  sample_t                  drive_r;
  sample_t                  y0_r;
  sample_t                  y1_r;
  tag_t                     tag0_r;
  tag_t                     tag_nxt;
  logic                     out_tvalid_r;
  logic [OUT_TDATA_W-1:0]   out_tdata_r;
  logic                     out_tuser_r;

  logic [IDX_W-1:0]         in_idx;
  sample_t                  in_value;
  logic                     in_xfer;
  logic                     c_wr_en;
  logic [CADDR_W-1:0]       c_rd_addr;
  logic [SADDR_W-1:0]       s_rd_addr;
  logic                     s_wr_en;
  logic [SADDR_W-1:0]       s_wr_addr;
  sample_t                  coeff_q;
  sample_t                  state_q;
  row_res_t                 res;

  // Input unpacking
  assign in_idx    = in_tdata[IDX_W-1:0];
  assign in_value  = in_tdata[VALUE_LSB +: SAMPLE_WIDTH];
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // Coefficient loads go straight into memory; out-of-range indexes are ignored.
  assign c_wr_en = in_xfer && in_tuser[0] && (int'(in_idx) < COEFF_COUNT);

  // Issue logic: pick the coefficient and operand for the current step.
  always_comb begin
    tag_nxt   = '0;
    c_rd_addr = '0;
    s_rd_addr = st_addr(bank_r, 0);
    case (state_r)
      ST_ROWS: begin
        tag_nxt.valid = 1'b1;
        tag_nxt.first = (col_r == '0);
        tag_nxt.last  = (col_r == COL_W'(ROW_LEN - 1));
        tag_nxt.row   = row_r;
        if (int'(col_r) < STATE_DIM) begin
          c_rd_addr = CADDR_W'(int'(row_r) * STATE_DIM + int'(col_r));
          s_rd_addr = st_addr(bank_r, int'(col_r));
        end else begin
          tag_nxt.use_meas = 1'b1;
          tag_nxt.msel     = MSEL_W'(int'(col_r) - STATE_DIM);
          c_rd_addr = CADDR_W'(G_BASE + int'(row_r) * MEAS_DIM + int'(col_r) - STATE_DIM);
        end
      end
      ST_HROW: begin
        tag_nxt.valid  = 1'b1;
        tag_nxt.first  = (row_r == '0);
        tag_nxt.last   = (row_r == ROW_W'(STATE_DIM - 1));
        tag_nxt.hphase = 1'b1;
        tag_nxt.row    = row_r;
        c_rd_addr = CADDR_W'(H_BASE + int'(row_r));
        s_rd_addr = st_addr(!bank_r, int'(row_r));
      end
      default: begin
      end
    endcase
  end

  // New state rows are written into the other bank, so old state stays readable.
  assign s_wr_en   = res.done && !res.hphase;
  assign s_wr_addr = st_addr(!bank_r, int'(res.row));

  osfc_ram #(
    .DEPTH (COEFF_COUNT),
    .WIDTH (SAMPLE_WIDTH)
  ) u_coeff_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (c_wr_en),
    .wr_addr (CADDR_W'(in_idx)),
    .wr_data (in_value),
    .rd_addr (c_rd_addr),
    .rd_data (coeff_q)
  );

  osfc_ram #(
    .DEPTH (2 * STATE_DIM),
    .WIDTH (SAMPLE_WIDTH)
  ) u_state_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (s_wr_en),
    .wr_addr (s_wr_addr),
    .wr_data (res.value),
    .rd_addr (s_rd_addr),
    .rd_data (state_q)
  );

  osfc_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .coeff_q     (coeff_q),
    .state_q     (state_q),
    .meas_first  (y0_r),
    .meas_second (y1_r),
    .tag_in      (tag0_r),
    .res         (res)
  );

  // Sequencer, state bank selection and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      row_r        <= '0;
      col_r        <= '0;
      gap_r        <= '0;
      bank_r       <= 1'b0;
      sat_r        <= 1'b0;
      tag0_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      tag0_r <= tag_nxt;

      // A transfer empties the output register unless a new result replaces it.
      if (out_tvalid_r && out_tready && (state_r != ST_PUSH)) begin
        out_tvalid_r <= 1'b0;
      end

      if (res.done && !res.hphase && res.clipped) begin
        sat_r <= 1'b1;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer && !in_tuser[0]) begin
            y0_r    <= in_tdata[MEAS0_LSB +: SAMPLE_WIDTH];
            y1_r    <= in_tdata[MEAS1_LSB +: SAMPLE_WIDTH];
            sat_r   <= 1'b0;
            row_r   <= '0;
            col_r   <= '0;
            state_r <= ST_ROWS;
          end
        end
        ST_ROWS: begin
          if (col_r == COL_W'(ROW_LEN - 1)) begin
            col_r <= '0;
            if (row_r == ROW_W'(STATE_DIM - 1)) begin
              row_r   <= '0;
              gap_r   <= '0;
              state_r <= ST_GAP;
            end else begin
              row_r <= row_r + 1'b1;
            end
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
        ST_GAP: begin
          // Wait until the last new state row has been written back.
          if (gap_r == 2'(GAP_LEN - 1)) begin
            state_r <= ST_HROW;
          end else begin
            gap_r <= gap_r + 1'b1;
          end
        end
        ST_HROW: begin
          if (row_r == ROW_W'(STATE_DIM - 1)) begin
            row_r   <= '0;
            state_r <= ST_DRAIN;
          end else begin
            row_r <= row_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (res.done && res.hphase) begin
            drive_r    <= res.value;
            pend_sat_r <= sat_r || res.clipped;
            bank_r     <= !bank_r;
            state_r    <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= OUT_TDATA_W'($unsigned(drive_r));
            out_tuser_r  <= pend_sat_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

endmodule
